[sv/tdpt_pkg.sv]
`default_nettype none
package tdpt_pkg;

  localparam int unsigned VALUE_BITS_DEF = 24;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } div_status_t;

endpackage
`default_nettype wire

[sv/tdpt_divider.sv]
`default_nettype none
module tdpt_divider #(
  parameter int unsigned VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF,
  parameter int unsigned DIV_BITS   = (VALUE_BITS + 1) / 2 + 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [VALUE_BITS-1:0]  dividend_i,
  input  wire logic [DIV_BITS-1:0]    divisor_i,
  output tdpt_pkg::div_status_t       status_o
);
  import tdpt_pkg::*;

  localparam int unsigned CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] dividend_q, dividend_d;
  logic [DIV_BITS-1:0]   divisor_q, divisor_d;
  logic [DIV_BITS-1:0]   rem_q, rem_d;
  logic [DIV_BITS:0]     trial;

  // One quotient bit per cycle; the remainder stays below the divisor.
  assign trial = {rem_q, dividend_q[VALUE_BITS-1]};

  always_comb begin
    busy_d     = busy_q;
    done_d     = 1'b0;
    cnt_d      = cnt_q;
    dividend_d = dividend_q;
    divisor_d  = divisor_q;
    rem_d      = rem_q;
    if (start_i) begin
      busy_d     = 1'b1;
      cnt_d      = CNT_BITS'(VALUE_BITS - 1);
      dividend_d = dividend_i;
      divisor_d  = divisor_i;
      rem_d      = '0;
    end else if (busy_q) begin
      dividend_d = {dividend_q[VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor_q}) begin
        rem_d = DIV_BITS'(trial - {1'b0, divisor_q});
      end else begin
        rem_d = trial[DIV_BITS-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    dividend_q <= dividend_d;
    divisor_q  <= divisor_d;
    rem_q      <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

endmodule
`default_nettype wire

[sv/trial_division_prime_test.sv]
`default_nettype none
// Each divisor check, from two up to floor(sqrt(n)), runs one remainder in the shared
// restoring divider; a zero remainder ends the test as not prime, and values below two are not prime.
// One request at a time: the input stalls until the result has gone to the result register.
// The result register lets a new request be taken while the previous result is still held.
// Reset is asynchronous and active low; it empties the sequencer and the result register.
module trial_division_prime_test #(
  parameter int unsigned VALUE_BITS = tdpt_pkg::VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [VALUE_BITS-1:0] candidate_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic                  prime_flag_o
);
  import tdpt_pkg::*;

  localparam int unsigned DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
  localparam int unsigned SQ_BITS  = VALUE_BITS + 2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [DIV_BITS-1:0]   d_q, d_d;
  logic [SQ_BITS-1:0]    sq_q, sq_d;
  logic                  res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_flag_q, out_flag_d;
  logic                  div_start;
  logic                  in_accept;
  logic                  out_free;
  div_status_t           div_status;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  tdpt_divider #(
    .VALUE_BITS(VALUE_BITS),
    .DIV_BITS  (DIV_BITS)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(n_q),
    .divisor_i (d_q),
    .status_o  (div_status)
  );

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    sq_d        = sq_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_flag_d  = out_flag_q;
    div_start   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          n_d  = candidate_i;
          d_d  = DIV_BITS'(2);
          sq_d = SQ_BITS'(4);
          if (candidate_i < VALUE_BITS'(2)) begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_q > {2'b00, n_q}) begin
          res_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          if (div_status.zero) begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            d_d     = d_q + 1'b1;
            sq_d    = sq_q + SQ_BITS'({d_q, 1'b1});
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_flag_d  = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    d_q        <= d_d;
    sq_q       <= sq_d;
    res_q      <= res_d;
    out_flag_q <= out_flag_d;
  end

  assign out_valid_o  = out_valid_q;
  assign prime_flag_o = out_flag_q;

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !div_status.busy && !div_status.done)
    else $error("divider active while sequencer idle");

  a_square_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> (sq_q == SQ_BITS'(d_q) * SQ_BITS'(d_q)))
    else $error("square register out of step with divisor");

  a_divisor_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (d_q >= DIV_BITS'(2)) && ({2'b00, n_q} >= sq_q))
    else $error("division started outside the divisor range");

  a_prime_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && res_q |-> (n_q >= VALUE_BITS'(2)))
    else $error("value below two reported as prime");

endmodule
`default_nettype wire
